// File: rtl/core/kerl_pkg.sv
// shared types and codes for the k-th element removal list
package kerl_pkg;

  // command codes of an input transaction
  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // status codes of a result transaction
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // fixed field widths
  localparam int unsigned ValueW = 32;
  localparam int unsigned PosW   = 11;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [ValueW-1:0] value;
    logic [PosW-1:0]   position;
  } item_t;

  typedef struct packed {
    logic [ValueW-1:0] removed_value;
    logic [1:0]        status;
    logic [PosW-1:0]   remaining;
  } result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND_RD,
    ST_FIND_CMP,
    ST_FOUND,
    ST_UPD_RD,
    ST_UPD_WR
  } state_e;

endpackage

// File: rtl/core/kerl_ram.sv
// simple dual-port synchronous ram, one write and one registered read port
module kerl_ram #(
  parameter int unsigned WIDTH   = 32,
  parameter int unsigned ENTRIES = 1024,
  parameter int unsigned AW      = $clog2(ENTRIES)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [ENTRIES];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered output
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/kth_element_removal_list_unit.sv
// k-th element removal list: fenwick count tree and value store in rams, sequencer
// sequence: append writes the value, strobes its result in the cycle after accept, then walks
//   the tree up; remove descends (per level a tree ram read and a compare, skipped past DEPTH),
//   fetches the value, then walks the tree up; an out-of-range remove is refused at accept
// throughput: one transaction at a time while busy is high; results are strobed, no stall
// reset and clear both sweep all DEPTH+1 entries of the count tree ram with busy high
module kth_element_removal_list_unit #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  kerl_pkg::item_t item_i,
  output logic            done_o,
  output kerl_pkg::result_t result_o
);

  localparam int unsigned IdxW    = $clog2(DEPTH + 1);
  localparam int unsigned VaW     = $clog2(DEPTH);
  localparam int unsigned KW      = (IdxW > kerl_pkg::PosW) ? IdxW : kerl_pkg::PosW;
  localparam int unsigned TopStep = 2 ** (IdxW - 1);
  localparam logic [IdxW:0] DepthL = (IdxW + 1)'(DEPTH);

  kerl_pkg::state_e state_q, state_d;
  logic [KW-1:0]    k_q, k_d;
  logic [IdxW:0]    pos_q, pos_d;
  logic [IdxW-1:0]  step_q, step_d;
  logic [IdxW:0]    idx_q, idx_d;
  logic             up_q, up_d;
  logic [IdxW-1:0]  live_q, live_d;
  logic [IdxW-1:0]  app_q, app_d;
  logic [IdxW-1:0]  clr_q, clr_d;
  logic             rep_q, rep_d;
  logic             val_pend_q, val_pend_d;
  logic             done_q, done_d;
  kerl_pkg::result_t res_q, res_d;

  // memory ports
  logic                  t_we, t_re;
  logic [IdxW-1:0]       t_waddr, t_raddr, t_wdata, t_rdata;
  logic                  v_we, v_re;
  logic [VaW-1:0]        v_waddr, v_raddr;
  logic [VALUE_BITS-1:0] v_wdata, v_rdata;

  // helpers
  logic [IdxW:0]   nxt_pos;
  logic [IdxW:0]   low_bit;
  logic [IdxW:0]   nxt_idx;
  logic [KW-1:0]   t_data_k;
  logic [KW-1:0]   pos_k;
  logic [KW-1:0]   live_k;
  logic [63:0]     in_wide;
  logic [63:0]     out_wide;
  logic [31:0]     live_wide;

  kerl_ram #(
    .WIDTH  (IdxW),
    .ENTRIES(DEPTH + 1)
  ) u_tree (
    .clk_i  (clk_i),
    .we_i   (t_we),
    .waddr_i(t_waddr),
    .wdata_i(t_wdata),
    .re_i   (t_re),
    .raddr_i(t_raddr),
    .rdata_o(t_rdata)
  );

  kerl_ram #(
    .WIDTH  (VALUE_BITS),
    .ENTRIES(DEPTH)
  ) u_values (
    .clk_i  (clk_i),
    .we_i   (v_we),
    .waddr_i(v_waddr),
    .wdata_i(v_wdata),
    .re_i   (v_re),
    .raddr_i(v_raddr),
    .rdata_o(v_rdata)
  );

  // shared arithmetic
  assign nxt_pos  = pos_q + (IdxW + 1)'(step_q);
  assign low_bit  = idx_q & (~idx_q + (IdxW + 1)'(1));
  assign nxt_idx  = idx_q + low_bit;
  assign t_data_k = KW'(t_rdata);
  assign pos_k    = KW'(item_i.position);
  assign live_k   = KW'(live_q);
  assign in_wide  = 64'(item_i.value);
  assign out_wide = 64'(v_rdata);

  // state register and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= kerl_pkg::ST_CLEAR;
      live_q     <= '0;
      app_q      <= '0;
      clr_q      <= '0;
      rep_q      <= 1'b0;
      val_pend_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      live_q     <= live_d;
      app_q      <= app_d;
      clr_q      <= clr_d;
      rep_q      <= rep_d;
      val_pend_q <= val_pend_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    pos_q  <= pos_d;
    step_q <= step_d;
    idx_q  <= idx_d;
    up_q   <= up_d;
    res_q  <= res_d;
  end

  // next state, memory control and results
  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    pos_d      = pos_q;
    step_d     = step_q;
    idx_d      = idx_q;
    up_d       = up_q;
    live_d     = live_q;
    app_d      = app_q;
    clr_d      = clr_q;
    rep_d      = rep_q;
    val_pend_d = val_pend_q;
    done_d     = 1'b0;
    res_d      = res_q;
    live_wide  = 32'(live_q);
    t_we       = 1'b0;
    t_waddr    = '0;
    t_wdata    = '0;
    t_re       = 1'b0;
    t_raddr    = '0;
    v_we       = 1'b0;
    v_waddr    = app_q[VaW-1:0];
    v_wdata    = in_wide[VALUE_BITS-1:0];
    v_re       = 1'b0;
    v_raddr    = pos_q[VaW-1:0];

    unique case (state_q)
      // zero the count tree one entry a cycle
      kerl_pkg::ST_CLEAR: begin
        t_we    = 1'b1;
        t_waddr = clr_q;
        t_wdata = '0;
        clr_d   = clr_q + IdxW'(1);
        if ((IdxW + 1)'(clr_q) == DepthL) begin
          clr_d   = '0;
          state_d = kerl_pkg::ST_IDLE;
          if (rep_q) begin
            rep_d               = 1'b0;
            done_d              = 1'b1;
            res_d.removed_value = '0;
            res_d.status        = kerl_pkg::STATUS_OK;
            res_d.remaining     = '0;
          end
        end
      end

      // take a new transaction
      kerl_pkg::ST_IDLE: begin
        if (start) begin
          res_d.removed_value = '0;
          res_d.status        = kerl_pkg::STATUS_OK;
          res_d.remaining     = live_wide[kerl_pkg::PosW-1:0];
          case (item_i.cmd)
            kerl_pkg::CMD_APPEND: begin
              done_d = 1'b1;
              if ((IdxW + 1)'(app_q) >= DepthL) begin
                res_d.status = kerl_pkg::STATUS_FULL;
              end else begin
                v_we            = 1'b1;
                app_d           = app_q + IdxW'(1);
                idx_d           = (IdxW + 1)'(app_q) + (IdxW + 1)'(1);
                up_d            = 1'b1;
                live_d          = live_q + IdxW'(1);
                live_wide       = 32'(live_d);
                res_d.remaining = live_wide[kerl_pkg::PosW-1:0];
                state_d         = kerl_pkg::ST_UPD_RD;
              end
            end
            kerl_pkg::CMD_REMOVE: begin
              if (pos_k == '0 || pos_k > live_k) begin
                done_d       = 1'b1;
                res_d.status = kerl_pkg::STATUS_RANGE;
              end else begin
                k_d     = pos_k;
                pos_d   = '0;
                step_d  = IdxW'(TopStep);
                state_d = kerl_pkg::ST_FIND_RD;
              end
            end
            kerl_pkg::CMD_CLEAR: begin
              app_d   = '0;
              live_d  = '0;
              clr_d   = '0;
              rep_d   = 1'b1;
              state_d = kerl_pkg::ST_CLEAR;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      // descent: fetch the candidate node
      kerl_pkg::ST_FIND_RD: begin
        if (nxt_pos <= DepthL) begin
          t_re    = 1'b1;
          t_raddr = nxt_pos[IdxW-1:0];
          state_d = kerl_pkg::ST_FIND_CMP;
        end else begin
          step_d = step_q >> 1;
          if (step_q == IdxW'(1)) begin
            state_d = kerl_pkg::ST_FOUND;
          end
        end
      end

      // descent: skip the node's subtree if it holds fewer than k
      kerl_pkg::ST_FIND_CMP: begin
        if (t_data_k < k_q) begin
          pos_d = nxt_pos;
          k_d   = k_q - t_data_k;
        end
        step_d  = step_q >> 1;
        state_d = (step_q == IdxW'(1)) ? kerl_pkg::ST_FOUND : kerl_pkg::ST_FIND_RD;
      end

      // element found at pos+1, fetch its value and start the decrement walk; refuse if pos is beyond the tree
      kerl_pkg::ST_FOUND: begin
        if (pos_q >= DepthL) begin
          done_d       = 1'b1;
          res_d.status = kerl_pkg::STATUS_RANGE;
          state_d      = kerl_pkg::ST_IDLE;
        end else begin
          v_re            = 1'b1;
          idx_d           = pos_q + (IdxW + 1)'(1);
          up_d            = 1'b0;
          live_d          = live_q - IdxW'(1);
          live_wide       = 32'(live_d);
          res_d.remaining = live_wide[kerl_pkg::PosW-1:0];
          val_pend_d      = 1'b1;
          state_d         = kerl_pkg::ST_UPD_RD;
        end
      end

      // first read of the update walk; report a removal here
      kerl_pkg::ST_UPD_RD: begin
        t_re    = 1'b1;
        t_raddr = idx_q[IdxW-1:0];
        state_d = kerl_pkg::ST_UPD_WR;
        if (val_pend_q) begin
          val_pend_d          = 1'b0;
          done_d              = 1'b1;
          res_d.removed_value = out_wide[31:0];
          res_d.status        = kerl_pkg::STATUS_OK;
        end
      end

      // write back the adjusted count and read the parent node
      kerl_pkg::ST_UPD_WR: begin
        t_we    = 1'b1;
        t_waddr = idx_q[IdxW-1:0];
        t_wdata = up_q ? (t_rdata + IdxW'(1)) : (t_rdata - IdxW'(1));
        if (nxt_idx <= DepthL) begin
          t_re    = 1'b1;
          t_raddr = nxt_idx[IdxW-1:0];
          idx_d   = nxt_idx;
        end else begin
          state_d = kerl_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = kerl_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy     = (state_q != kerl_pkg::ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
